### hw/rtl/page_migration_completion_tracker_macros.svh
// Assertion macros for the page migration completion tracker.
`ifndef PAGE_MIGRATION_COMPLETION_TRACKER_MACROS_SVH
`define PAGE_MIGRATION_COMPLETION_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PMCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMCT_ASSERT(lbl, prop, msg)
`define PMCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/pmct_pkg.sv
// Shared types, constants and helpers of the page migration completion tracker.
package pmct_pkg;

  localparam int unsigned NUM_SOCKETS_DEF    = 16;
  localparam int unsigned LINES_PER_PAGE_DEF = 64;
  localparam int unsigned BUCKET_CYCLES_DEF  = 24;
  localparam int unsigned LAST_BUCKET_DEF    = 99;

  localparam int unsigned PAGE_W   = 52;
  localparam int unsigned CYCLE_W  = 48;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned LEFT_W   = 7;
  localparam int unsigned CLOSED_W = 7;   // up to 64 slots closing on one word
  localparam int unsigned TSUM_W   = 54;  // up to 64 page times of 48 bits
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned BUCKET_W = 7;

  localparam logic OP_OPEN   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SLOT_W-1:0]   dest_slot;
    logic [PAGE_W-1:0]   page_number;
    logic [CYCLE_W-1:0]  now_cycle;
    logic [CYCLE_W-1:0]  enqueue_cycle;
  } in_t;

  typedef struct packed {
    logic                slot_matched;
    logic [SLOT_W-1:0]   pages_finished_now;
    logic [BUCKET_W-1:0] latency_bucket;
    logic                sample_dropped;
    logic [CNT_W-1:0]    bucket_count;
    logic [CNT_W-1:0]    pages_total;
    logic [SUM_W-1:0]    page_time_total;
    logic [CNT_W-1:0]    cxl_pages_total;
    logic [SUM_W-1:0]    cxl_time_total;
    logic [CNT_W-1:0]    lines_total;
    logic [SUM_W-1:0]    line_latency_total;
  } out_t;

  // Token handed from slot cell to slot cell, collecting what each cell did.
  typedef struct packed {
    logic                vld;
    logic                op;
    logic [SLOT_W-1:0]   dest_slot;
    logic                active;
    logic [PAGE_W-1:0]   page;
    logic [CYCLE_W-1:0]  now;
    logic                matched;
    logic [CLOSED_W-1:0] closed;
    logic [TSUM_W-1:0]   time_sum;
    logic                cxl_closed;
    logic [CYCLE_W-1:0]  cxl_time;
  } tok_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

### hw/rtl/page_migration_completion_tracker.sv
// A word is accepted only while idle. It walks through the chain of NUM_SOCKETS + 1 slot cells while
// its bucket is divided out, and then the histogram is read, modified and written.
// No new word is taken until then: busy stays high from acceptance to the end of the write.
// The receiver cannot stall: done_o is high for exactly one cycle per word.
// Reset clears all slots, the histogram valid bits, the totals and the counting enable.
// Slot contents and histogram storage have no reset and are only read once written.
`include "page_migration_completion_tracker_macros.svh"

module page_migration_completion_tracker #(
  parameter int unsigned NUM_SOCKETS    = pmct_pkg::NUM_SOCKETS_DEF,
  parameter int unsigned LINES_PER_PAGE = pmct_pkg::LINES_PER_PAGE_DEF,
  parameter int unsigned BUCKET_CYCLES  = pmct_pkg::BUCKET_CYCLES_DEF,
  parameter int unsigned LAST_BUCKET    = pmct_pkg::LAST_BUCKET_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pmct_pkg::in_t  in_i,
  output logic           done_o,
  output pmct_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);

  localparam int unsigned NSLOTS   = NUM_SOCKETS + 1;
  localparam int unsigned NBUCKETS = LAST_BUCKET + 1;
  localparam int unsigned LIM      = BUCKET_CYCLES * LAST_BUCKET;
  localparam int unsigned DW       = $clog2(LIM + 1);
  localparam int unsigned BW       = $clog2(NBUCKETS);
  localparam logic [pmct_pkg::CYCLE_W-1:0] LAT_LIMIT = pmct_pkg::CYCLE_W'(LIM);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                           en_q;
  logic                           launch_q;
  logic                           done_q;
  logic                           fin_vld_q;
  pmct_pkg::in_t                  item_q;
  logic                           item_en_q;
  logic [pmct_pkg::CYCLE_W-1:0]   lat_q;
  logic                           neg_q, clamp_q;
  pmct_pkg::tok_t                 tok_head;
  pmct_pkg::tok_t                 tok_chain [NSLOTS+1];
  pmct_pkg::tok_t                 fin_q;
  logic [BW-1:0]                  div_quot, bucket_sel, rd_addr_q;
  logic                           div_done;
  logic                           accept;

  logic [pmct_pkg::CNT_W-1:0]     hist_mem [NBUCKETS];
  logic [NBUCKETS-1:0]            hist_vld_q;
  logic [pmct_pkg::CNT_W-1:0]     rd_data_q, old_cnt, new_cnt;
  logic                           rd_vld_q;
  logic                           counted, dropped, hist_we;

  logic [pmct_pkg::CNT_W-1:0]     pages_q, cxl_pages_q, lines_q, bcount_q;
  logic [pmct_pkg::SUM_W-1:0]     time_q, cxl_time_q, lat_sum_q;
  logic [pmct_pkg::CNT_W:0]       pages_sum;
  logic                           res_matched_q, res_dropped_q;
  logic [pmct_pkg::SLOT_W-1:0]    res_closed_q;
  logic [31:0]                    bucket_ext;
  logic [pmct_pkg::BUCKET_W-1:0]  res_bucket_q;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Chain of slot cells; the word enters the first cell the cycle after acceptance.
  always_comb begin
    tok_head            = '0;
    tok_head.vld        = launch_q;
    tok_head.op         = item_q.op;
    tok_head.dest_slot  = item_q.dest_slot;
    tok_head.active     = (item_q.op == pmct_pkg::OP_RETURN) && item_en_q;
    tok_head.page       = item_q.page_number;
    tok_head.now        = item_q.now_cycle;
  end

  assign tok_chain[0] = tok_head;

  for (genvar g = 0; g < NSLOTS; g++) begin : g_cell
    pmct_slot_cell #(
      .IDX            (g),
      .IS_CXL         (g == NUM_SOCKETS),
      .LINES_PER_PAGE (LINES_PER_PAGE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_chain[g]),
      .tok_o  (tok_chain[g+1])
    );
  end

  pmct_bucket_div #(
    .BUCKET_CYCLES (BUCKET_CYCLES),
    .LAST_BUCKET   (LAST_BUCKET)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (launch_q),
    .dividend_i (lat_q[DW-1:0]),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign bucket_sel = clamp_q ? BW'(LAST_BUCKET) : div_quot;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_WALK;
      ST_WALK:  if (fin_vld_q && div_done) state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign counted = item_q.op == pmct_pkg::OP_RETURN && item_en_q && !neg_q;
  assign dropped = item_q.op == pmct_pkg::OP_RETURN && (!item_en_q || neg_q);
  assign old_cnt = rd_vld_q ? rd_data_q : '0;
  assign new_cnt = pmct_pkg::sat_inc(old_cnt);
  assign hist_we = (state_q == ST_WRITE) && counted;
  assign pages_sum = {1'b0, pages_q} + (pmct_pkg::CNT_W + 1)'(fin_q.closed);
  assign bucket_ext = 32'(rd_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      launch_q    <= 1'b0;
      done_q      <= 1'b0;
      fin_vld_q   <= 1'b0;
      hist_vld_q  <= '0;
      pages_q     <= '0;
      time_q      <= '0;
      cxl_pages_q <= '0;
      cxl_time_q  <= '0;
      lines_q     <= '0;
      lat_sum_q   <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
      done_q   <= (state_q == ST_WRITE);
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (tok_chain[NSLOTS].vld) begin
        fin_vld_q <= 1'b1;
      end else if (state_q == ST_READ) begin
        fin_vld_q <= 1'b0;
      end
      if (hist_we) begin
        hist_vld_q[rd_addr_q] <= 1'b1;
      end
      if (state_q == ST_WRITE) begin
        pages_q <= pages_sum[pmct_pkg::CNT_W] ? {pmct_pkg::CNT_W{1'b1}}
                                              : pages_sum[pmct_pkg::CNT_W-1:0];
        time_q  <= time_q + pmct_pkg::SUM_W'(fin_q.time_sum);
        if (fin_q.cxl_closed) begin
          cxl_pages_q <= pmct_pkg::sat_inc(cxl_pages_q);
          cxl_time_q  <= cxl_time_q + pmct_pkg::SUM_W'(fin_q.cxl_time);
        end
        if (counted) begin
          lines_q   <= pmct_pkg::sat_inc(lines_q);
          lat_sum_q <= lat_sum_q + pmct_pkg::SUM_W'(lat_q);
        end
      end
    end
  end

  // Word capture, latency precompute and the result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q    <= in_i;
      item_en_q <= en_q;
      lat_q     <= in_i.now_cycle - in_i.enqueue_cycle;
      neg_q     <= in_i.now_cycle < in_i.enqueue_cycle;
      clamp_q   <= (in_i.now_cycle - in_i.enqueue_cycle) >= LAT_LIMIT;
    end
    if (tok_chain[NSLOTS].vld) begin
      fin_q <= tok_chain[NSLOTS];
    end
    if (state_q == ST_READ) begin
      rd_addr_q <= bucket_sel;
      rd_vld_q  <= hist_vld_q[bucket_sel];
    end
    if (state_q == ST_WRITE) begin
      res_matched_q <= fin_q.matched;
      res_closed_q  <= fin_q.closed[pmct_pkg::SLOT_W-1:0];
      res_dropped_q <= dropped;
      res_bucket_q  <= counted ? bucket_ext[pmct_pkg::BUCKET_W-1:0] : '0;
      bcount_q      <= counted ? new_cnt : '0;
    end
  end

  // Histogram storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_data_q <= hist_mem[bucket_sel];
    end
    if (hist_we) begin
      hist_mem[rd_addr_q] <= new_cnt;
    end
  end

  assign done_o = done_q;

  always_comb begin
    out_o.slot_matched       = res_matched_q;
    out_o.pages_finished_now = res_closed_q;
    out_o.latency_bucket     = res_bucket_q;
    out_o.sample_dropped     = res_dropped_q;
    out_o.bucket_count       = bcount_q;
    out_o.pages_total        = pages_q;
    out_o.page_time_total    = time_q;
    out_o.cxl_pages_total    = cxl_pages_q;
    out_o.cxl_time_total     = cxl_time_q;
    out_o.lines_total        = lines_q;
    out_o.line_latency_total = lat_sum_q;
  end

  `PMCT_ASSERT_NEXT(a_write_gives_done, state_q == ST_WRITE, done_q, "no strobe after write")
  `PMCT_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held too long")
  `PMCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && launch_q, "word did not launch")
  `PMCT_ASSERT(a_fin_walk, !fin_vld_q || state_q == ST_WALK || state_q == ST_READ, "late chain")

endmodule

### hw/rtl/pmct_slot_cell.sv
// One destination slot cell of the tracker chain.
module pmct_slot_cell #(
  parameter int unsigned IDX            = 0,
  parameter bit          IS_CXL         = 1'b0,
  parameter int unsigned LINES_PER_PAGE = pmct_pkg::LINES_PER_PAGE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pmct_pkg::tok_t tok_i,
  output pmct_pkg::tok_t tok_o
);

  localparam logic [31:0] IDX_U = 32'(IDX);
  localparam logic [pmct_pkg::LEFT_W-1:0] LEFT_INIT = pmct_pkg::LEFT_W'(LINES_PER_PAGE);

  logic                            open_q, open_d;
  logic [pmct_pkg::PAGE_W-1:0]     page_q, page_d;
  logic [pmct_pkg::LEFT_W-1:0]     left_q, left_d, left_dec;
  logic [pmct_pkg::CYCLE_W-1:0]    start_q, start_d, page_time;
  pmct_pkg::tok_t                  tok_q, tok_d;
  logic                            hit;

  always_comb begin
    tok_d     = tok_i;
    open_d    = open_q;
    page_d    = page_q;
    left_d    = left_q;
    start_d   = start_q;
    left_dec  = left_q - pmct_pkg::LEFT_W'(1);
    page_time = tok_i.now - start_q;
    hit       = tok_i.vld && tok_i.active && open_q && (page_q == tok_i.page);
    if (tok_i.vld && (tok_i.op == pmct_pkg::OP_OPEN) && (32'(tok_i.dest_slot) == IDX_U)) begin
      open_d  = 1'b1;
      page_d  = tok_i.page;
      left_d  = LEFT_INIT;
      start_d = tok_i.now;
    end
    if (hit) begin
      tok_d.matched = 1'b1;
      left_d        = left_dec;
      if (left_dec == '0) begin
        open_d         = 1'b0;
        tok_d.closed   = tok_i.closed + pmct_pkg::CLOSED_W'(1);
        tok_d.time_sum = tok_i.time_sum + pmct_pkg::TSUM_W'(page_time);
        if (IS_CXL) begin
          tok_d.cxl_closed = 1'b1;
          tok_d.cxl_time   = page_time;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      open_q <= open_d;
      tok_q  <= tok_d;
    end
  end

  // Slot contents only mean something while the slot is open.
  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    left_q  <= left_d;
    start_q <= start_d;
  end

  assign tok_o = tok_q;

endmodule

### hw/rtl/pmct_bucket_div.sv
// Reciprocal multiplier that turns a line latency into its histogram bucket.
module pmct_bucket_div #(
  parameter int unsigned BUCKET_CYCLES = pmct_pkg::BUCKET_CYCLES_DEF,
  parameter int unsigned LAST_BUCKET   = pmct_pkg::LAST_BUCKET_DEF,
  localparam int unsigned LIM  = BUCKET_CYCLES * LAST_BUCKET,
  localparam int unsigned DW   = $clog2(LIM + 1),
  localparam int unsigned QW   = $clog2(LAST_BUCKET + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic [QW-1:0] quot_o,
  output logic          done_o
);

  // With the reciprocal rounded up and this shift, the product gives the exact quotient
  // for every dividend of DW bits.
  localparam int unsigned SH = DW + $clog2(BUCKET_CYCLES);
  localparam int unsigned PW = DW + SH + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(BUCKET_CYCLES) - 64'd1) / 64'(BUCKET_CYCLES);
  localparam logic [SH:0] RECIP = (SH + 1)'(RECIP_L);

  logic [DW-1:0] dvd_q;
  logic [QW-1:0] quo_q;
  logic [PW-1:0] prod;
  logic          pend_q, done_q;

  assign prod = {{(SH + 1){1'b0}}, dvd_q} * {{DW{1'b0}}, RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      pend_q <= 1'b1;
      done_q <= 1'b0;
    end else if (pend_q) begin
      pend_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (pend_q) begin
      quo_q <= prod[SH +: QW];
    end
  end

  // For a dividend below LIM the quotient stays below LAST_BUCKET, so its low QW bits carry all of it.
  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

### sim/tb_page_migration_completion_tracker.sv
// Self-checking testbench for the page migration completion tracker.
module tb_page_migration_completion_tracker;

  localparam int unsigned SLOTS     = pmct_pkg::NUM_SOCKETS_DEF + 1;
  localparam int unsigned NBINS     = pmct_pkg::LAST_BUCKET_DEF + 1;
  localparam int unsigned LAT_CLAMP = pmct_pkg::BUCKET_CYCLES_DEF * NBINS;
  localparam int unsigned QUIET_MAX = 1000;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  logic           busy;
  pmct_pkg::in_t  in_i;
  logic           done_o;
  pmct_pkg::out_t out_o;
  logic           cfg_we_i;
  logic           cfg_wdata_i;

  page_migration_completion_tracker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Tracker state as the testbench sees it.
  bit                           counting_on;
  bit                           slot_live [SLOTS];
  logic [pmct_pkg::PAGE_W-1:0]  slot_pg   [SLOTS];
  int                           slot_left [SLOTS];
  logic [pmct_pkg::CYCLE_W-1:0] slot_t0   [SLOTS];
  bit   [pmct_pkg::CNT_W-1:0]   bin_count [NBINS];
  bit   [pmct_pkg::CNT_W-1:0]   pages_done;
  bit   [pmct_pkg::SUM_W-1:0]   page_cycles;
  bit   [pmct_pkg::CNT_W-1:0]   cxl_pages_done;
  bit   [pmct_pkg::SUM_W-1:0]   cxl_cycles;
  bit   [pmct_pkg::CNT_W-1:0]   lines_done;
  bit   [pmct_pkg::SUM_W-1:0]   latency_cycles;

  pmct_pkg::out_t               pending_reports [$];
  pmct_pkg::out_t               want;
  logic [pmct_pkg::PAGE_W-1:0]  page_pool [3];
  int                           idle_pct;
  int                           n_fail;
  int                           quiet_cycles;

  function automatic bit [pmct_pkg::CNT_W-1:0] bump32(input bit [pmct_pkg::CNT_W-1:0] v);
    return (v == {pmct_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [pmct_pkg::CYCLE_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[pmct_pkg::CYCLE_W-1:0];
  endfunction

  function automatic logic [pmct_pkg::PAGE_W-1:0] rand52();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[pmct_pkg::PAGE_W-1:0];
  endfunction

  // Works out the report for one accepted word and advances the tracker state.
  task automatic track_word(input pmct_pkg::in_t w);
    pmct_pkg::out_t               r;
    logic [pmct_pkg::CYCLE_W-1:0] span;
    logic [pmct_pkg::CYCLE_W-1:0] lat;
    int unsigned                  b;
    int                           closed;
    r = '0;
    closed = 0;
    if (w.op == pmct_pkg::OP_OPEN) begin
      if (w.dest_slot < SLOTS) begin
        slot_live[w.dest_slot] = 1'b1;
        slot_pg[w.dest_slot]   = w.page_number;
        slot_left[w.dest_slot] = pmct_pkg::LINES_PER_PAGE_DEF;
        slot_t0[w.dest_slot]   = w.now_cycle;
      end
    end else if (!counting_on) begin
      r.sample_dropped = 1'b1;
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_live[s] && slot_pg[s] == w.page_number) begin
          r.slot_matched = 1'b1;
          slot_left[s]--;
          if (slot_left[s] == 0) begin
            span = w.now_cycle - slot_t0[s];
            slot_live[s] = 1'b0;
            closed++;
            pages_done  = bump32(pages_done);
            page_cycles = page_cycles + pmct_pkg::SUM_W'(span);
            if (s == pmct_pkg::NUM_SOCKETS_DEF) begin
              cxl_pages_done = bump32(cxl_pages_done);
              cxl_cycles     = cxl_cycles + pmct_pkg::SUM_W'(span);
            end
          end
        end
      end
      if (w.now_cycle < w.enqueue_cycle) begin
        r.sample_dropped = 1'b1;
      end else begin
        lat = w.now_cycle - w.enqueue_cycle;
        b = (lat / pmct_pkg::BUCKET_CYCLES_DEF > pmct_pkg::LAST_BUCKET_DEF)
            ? pmct_pkg::LAST_BUCKET_DEF : int'(lat / pmct_pkg::BUCKET_CYCLES_DEF);
        bin_count[b]     = bump32(bin_count[b]);
        r.latency_bucket = pmct_pkg::BUCKET_W'(b);
        r.bucket_count   = bin_count[b];
        lines_done       = bump32(lines_done);
        latency_cycles   = latency_cycles + pmct_pkg::SUM_W'(lat);
      end
    end
    r.pages_finished_now = pmct_pkg::SLOT_W'(closed);
    r.pages_total        = pages_done;
    r.page_time_total    = page_cycles;
    r.cxl_pages_total    = cxl_pages_done;
    r.cxl_time_total     = cxl_cycles;
    r.lines_total        = lines_done;
    r.line_latency_total = latency_cycles;
    pending_reports.insert(pending_reports.size(), r);
  endtask

  // Start stays high after acceptance, so the caller sends again or drains straight away.
  task automatic send_word(input pmct_pkg::in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    track_word(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Only called once the tracker is idle.
  task automatic write_counting(input bit en);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    counting_on = en;
  endtask

  function automatic pmct_pkg::in_t page_open(input int unsigned slot,
                                              input logic [pmct_pkg::PAGE_W-1:0] pg);
    pmct_pkg::in_t w;
    w.op            = pmct_pkg::OP_OPEN;
    w.dest_slot     = pmct_pkg::SLOT_W'(slot);
    w.page_number   = pg;
    w.now_cycle     = rand48();
    w.enqueue_cycle = rand48();
    return w;
  endfunction

  function automatic pmct_pkg::in_t line_return(input logic [pmct_pkg::PAGE_W-1:0] pg,
                                                input logic [pmct_pkg::CYCLE_W-1:0] now,
                                                input logic [pmct_pkg::CYCLE_W-1:0] enq);
    pmct_pkg::in_t w;
    w.op            = pmct_pkg::OP_RETURN;
    w.dest_slot     = pmct_pkg::SLOT_W'($urandom);
    w.page_number   = pg;
    w.now_cycle     = now;
    w.enqueue_cycle = enq;
    return w;
  endfunction

  // A returned line with a latency that is in range half the time, often near the clamp,
  // sometimes negative and sometimes anything at all.
  function automatic pmct_pkg::in_t random_return(input logic [pmct_pkg::PAGE_W-1:0] pg);
    logic [pmct_pkg::CYCLE_W-1:0] now;
    logic [pmct_pkg::CYCLE_W-1:0] enq;
    int unsigned                  pick;
    now  = rand48();
    pick = $urandom_range(99);
    if (pick < 50)      enq = now - $urandom_range(0, LAT_CLAMP - 1);
    else if (pick < 70) enq = now - $urandom_range(LAT_CLAMP - 30, LAT_CLAMP + 30);
    else if (pick < 80) enq = now - rand48();
    else if (pick < 90) enq = now + $urandom_range(1, 5000);
    else                enq = rand48();
    return line_return(pg, now, enq);
  endfunction

  function automatic pmct_pkg::in_t stray_word();
    pmct_pkg::in_t w;
    w.op            = 1'($urandom);
    w.dest_slot     = pmct_pkg::SLOT_W'($urandom);
    w.page_number   = rand52();
    w.now_cycle     = rand48();
    w.enqueue_cycle = rand48();
    return w;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $error("report arrived with none expected");
        n_fail++;
      end else begin
        want = pending_reports.pop_front();
        check_field("slot_matched", want.slot_matched, out_o.slot_matched);
        check_field("pages_finished_now", want.pages_finished_now, out_o.pages_finished_now);
        check_field("latency_bucket", want.latency_bucket, out_o.latency_bucket);
        check_field("sample_dropped", want.sample_dropped, out_o.sample_dropped);
        check_field("bucket_count", want.bucket_count, out_o.bucket_count);
        check_field("pages_total", want.pages_total, out_o.pages_total);
        check_field("page_time_total", want.page_time_total, out_o.page_time_total);
        check_field("cxl_pages_total", want.cxl_pages_total, out_o.cxl_pages_total);
        check_field("cxl_time_total", want.cxl_time_total, out_o.cxl_time_total);
        check_field("lines_total", want.lines_total, out_o.lines_total);
        check_field("line_latency_total", want.line_latency_total, out_o.line_latency_total);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Opens are not gated by the enable, but returns are dropped until it is set.
  task automatic test_disabled_after_reset();
    send_word(page_open(3, page_pool[0]));
    send_word(line_return(page_pool[0], {pmct_pkg::CYCLE_W{1'b1}}, '0));
    drain();
    write_counting(1'b1);
  endtask

  task automatic test_open_corners();
    send_word(page_open(0, '0));
    send_word(page_open(pmct_pkg::NUM_SOCKETS_DEF, {pmct_pkg::PAGE_W{1'b1}}));
    send_word(page_open(SLOTS, '0));
    send_word(page_open({pmct_pkg::SLOT_W{1'b1}}, {pmct_pkg::PAGE_W{1'b1}}));
    send_word(page_open(7, page_pool[1]));
    // Reopening a slot replaces its page and restarts its line count.
    send_word(page_open(7, page_pool[2]));
  endtask

  task automatic test_return_corners();
    logic [pmct_pkg::CYCLE_W-1:0] t;
    t = rand48();
    send_word(line_return('0, t, t));
    send_word(line_return({pmct_pkg::PAGE_W{1'b1}}, {pmct_pkg::CYCLE_W{1'b1}}, '0));
    send_word(line_return(page_pool[2], t, t - 23));
    send_word(line_return(page_pool[2], t, t - 24));
    send_word(line_return(page_pool[2], t, t - (LAT_CLAMP - 25)));
    send_word(line_return(page_pool[2], t, t - (LAT_CLAMP - 24)));
    send_word(line_return(page_pool[1], t, t - 100));
    send_word(line_return('0, '0, {pmct_pkg::CYCLE_W{1'b1}}));
    send_word(line_return(page_pool[0], t, t + 1));
    send_word(line_return(rand52(), rand48(), rand48()));
    drain();
  endtask

  // Groups of slots are opened on one page and then fed its lines, with stray words
  // mixed in; a few groups stop short and are left to be overwritten later.
  task automatic test_page_bursts(input int n_words, input int pct, input bit full_set);
    logic [pmct_pkg::PAGE_W-1:0] pg;
    int                          nslots;
    int                          nret;
    int                          sent;
    idle_pct = pct;
    sent = 0;
    while (sent < n_words) begin
      pg = ($urandom_range(9) < 7) ? page_pool[$urandom_range(2)] : rand52();
      if (full_set) nslots = SLOTS;
      else if ($urandom_range(3) == 0) nslots = $urandom_range(1, SLOTS);
      else nslots = $urandom_range(1, 3);
      for (int k = 0; k < nslots; k++) begin
        send_word(page_open(full_set ? k : $urandom_range(0, SLOTS - 1), pg));
        sent++;
      end
      full_set = 1'b0;
      nret = ($urandom_range(7) == 0)
             ? $urandom_range(1, pmct_pkg::LINES_PER_PAGE_DEF - 1)
             : pmct_pkg::LINES_PER_PAGE_DEF + $urandom_range(0, 2);
      for (int k = 0; k < nret; k++) begin
        if ($urandom_range(9) == 0) begin
          send_word(stray_word());
          sent++;
        end
        send_word(random_return(pg));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    start       = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    rst_ni      = 1'b0;
    idle_pct    = 0;
    n_fail      = 0;
    for (int i = 0; i < 3; i++) page_pool[i] = rand52();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_disabled_after_reset();
    test_open_corners();
    test_return_corners();
    test_page_bursts(450, 0, 1'b1);
    test_page_bursts(450, 47, 1'b0);
    write_counting(1'b0);
    test_page_bursts(100, 8, 1'b0);
    write_counting(1'b1);
    test_page_bursts(350, 8, 1'b0);

    repeat (40) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      n_fail++;
    end
    if (n_fail == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pmct_pkg.sv
hw/rtl/pmct_slot_cell.sv
hw/rtl/pmct_bucket_div.sv
hw/rtl/page_migration_completion_tracker.sv
sim/tb_page_migration_completion_tracker.sv
